>>> design/kpc_pkg.sv
// Shared types and constants for the key press classifier.
// No dependencies; imported by kpc_fsm and key_press_classifier.
package kpc_pkg;

  // Field widths
  localparam int KEY_W   = 3;   // sampled key levels
  localparam int CODE_W  = 4;   // event code
  localparam int IDX_W   = 2;   // tracked key number
  localparam int TIMER_W = 16;  // phase timer and 16-bit thresholds
  localparam int LOCK_W  = 8;   // lockout counter and threshold
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_HOLDOFF = 8'd3;

  // Register reset values
  localparam logic [TIMER_W-1:0] LONG_TICKS_RST     = 16'd500;
  localparam logic [TIMER_W-1:0] DOUBLE_WINDOW_RST  = 16'd150;
  localparam logic [LOCK_W-1:0]  LOCKOUT_TICKS_RST  = 8'd50;
  localparam logic [TIMER_W-1:0] DOUBLE_HOLDOFF_RST = 16'd150;

  // Event code bases, key number is added on top
  localparam logic [CODE_W-1:0] CODE_SHORT  = 4'd1;
  localparam logic [CODE_W-1:0] CODE_DOUBLE = 4'd4;
  localparam logic [CODE_W-1:0] CODE_LONG   = 4'd7;

  // Timing settings handed from the register bank to the classifier
  typedef struct packed {
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] double_window;
    logic [LOCK_W-1:0]  lockout_ticks;
    logic [TIMER_W-1:0] double_holdoff;
  } kpc_cfg_t;

  // One classified event
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } kpc_event_t;

endpackage

>>> design/kpc_fsm.sv
// Press classifier state machine: phase, tracked key, phase timer, lockout.
// Depends on kpc_pkg; one sample is processed on each cycle step is high.
module kpc_fsm
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [KEY_W-1:0] keys,
  input  kpc_cfg_t         cfg,
  output kpc_event_t       evt
);

  localparam int KEYS_USED = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HELD    = 2'd1,
    PH_WINDOW  = 2'd2,
    PH_HOLDOFF = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   key_r, key_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [LOCK_W-1:0]  lock_r, lock_nxt;

  logic [TIMER_W-1:0] timer_up;
  logic               found;
  logic [IDX_W-1:0]   first_idx;
  logic               down;
  logic               cleared;
  logic               emit;
  logic [CODE_W-1:0]  code;

  // Saturating timer increment
  assign timer_up = (timer_r == {TIMER_W{1'b1}}) ? timer_r : timer_r + 1'b1;

  // Lowest-numbered pressed key among those in use
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = KEYS_USED - 1; i >= 0; i--) begin
      if (keys[i]) begin
        found     = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  assign down = keys[key_r];

  // Next state and event for this sample
  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    timer_nxt = timer_r;
    cleared   = 1'b0;
    emit      = 1'b0;
    code      = '0;
    case (phase_r)
      PH_IDLE: begin
        if (found) begin
          if (lock_r < cfg.lockout_ticks) begin
            cleared = 1'b1;
          end else begin
            key_nxt   = first_idx;
            timer_nxt = TIMER_W'(1);
            if (cfg.long_ticks <= TIMER_W'(1)) begin
              emit      = 1'b1;
              code      = CODE_LONG + {2'b00, first_idx};
              cleared   = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_HELD;
            end
          end
        end
      end
      PH_HELD: begin
        if (down) begin
          timer_nxt = timer_up;
          if (timer_up >= cfg.long_ticks) begin
            emit      = 1'b1;
            code      = CODE_LONG + {2'b00, key_r};
            cleared   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end else begin
          timer_nxt = TIMER_W'(1);
          if (cfg.double_window <= TIMER_W'(1)) begin
            emit      = 1'b1;
            code      = CODE_SHORT + {2'b00, key_r};
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_WINDOW;
          end
        end
      end
      PH_WINDOW: begin
        if (down) begin
          emit      = 1'b1;
          code      = CODE_DOUBLE + {2'b00, key_r};
          timer_nxt = '0;
          phase_nxt = (cfg.double_holdoff == '0) ? PH_IDLE : PH_HOLDOFF;
        end else begin
          timer_nxt = timer_up;
          if (timer_up >= cfg.double_window) begin
            emit      = 1'b1;
            code      = CODE_SHORT + {2'b00, key_r};
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_HOLDOFF: begin
        timer_nxt = timer_up;
        if (timer_up >= cfg.double_holdoff) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Lockout counter: clear or count up, saturating
  always_comb begin
    if (cleared) lock_nxt = '0;
    else if (lock_r == {LOCK_W{1'b1}}) lock_nxt = lock_r;
    else lock_nxt = lock_r + 1'b1;
  end

  assign evt.valid = step & emit;
  assign evt.code  = code;

  // Hold state between samples, advance on step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      key_r   <= '0;
      timer_r <= '0;
      lock_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      key_r   <= key_nxt;
      timer_r <= timer_nxt;
      lock_r  <= lock_nxt;
    end
  end

endmodule

>>> design/key_press_classifier.sv
// Key press classifier top level: register bank, input and result registers.
// Depends on kpc_pkg and kpc_fsm.
//
// One key sample is taken per cycle while the input is not stalled. A word
// accepted on the input stream is held in the input register and classified
// from there. If it completes a press, the event code is loaded into the
// result register and presented on the output stream from there. Throughput
// is one word per cycle while the result register drains. When a result waits
// untaken, the input register takes at most one more word and holds it, and
// the input stalls until the result is taken. Configuration writes are taken
// in any cycle and should only be issued while no sample is in flight. No
// clearing pass is needed after reset.
module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [2:0] key_levels
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [3:0] event_code
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kpc_cfg_t          cfg_r;
  logic              in_valid_r;
  logic [KEY_W-1:0]  in_keys_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              step;
  kpc_event_t        evt;

  // Register bank, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks     <= LONG_TICKS_RST;
      cfg_r.double_window  <= DOUBLE_WINDOW_RST;
      cfg_r.lockout_ticks  <= LOCKOUT_TICKS_RST;
      cfg_r.double_holdoff <= DOUBLE_HOLDOFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LONG_TICKS:     cfg_r.long_ticks     <= cfg_data;
        REG_DOUBLE_WINDOW:  cfg_r.double_window  <= cfg_data;
        REG_LOCKOUT_TICKS:  cfg_r.lockout_ticks  <= cfg_data[LOCK_W-1:0];
        REG_DOUBLE_HOLDOFF: cfg_r.double_holdoff <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process the held word when the result register has room
  assign step      = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_keys_r <= in_tdata[KEY_W-1:0];
  end

  kpc_fsm #(
    .NUM_KEYS(NUM_KEYS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .keys  (in_keys_r),
    .cfg   (cfg_r),
    .evt   (evt)
  );

  // Result register: load a new event, drop a taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (evt.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) out_code_r <= evt.code;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - CODE_W){1'b0}}, out_code_r};

endmodule

>>> design/kpc_checker.sv
// Port-level checks for the key press classifier, bound to its top level.
// Depends on key_press_classifier.
module kpc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Only codes one to nine, upper bits zero
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] != 4'd0) && (out_tdata[3:0] <= 4'd9)
                   && (out_tdata[7:4] == 4'd0))
    else $error("event code out of range");

  // A fresh result traces back to an accepted input word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching input word");

  // Result channel empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (.*);
